@@ sv/cdq_pkg.sv @@
// Shared constants, request/status codes and cell control type for the deque.
package cdq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	// Row-wide moves, common to every cell.
	typedef struct packed {
		logic push_front;
		logic pop_front;
		logic push_back;
	} cell_ctl_t;

endpackage

@@ sv/cdq_cell.sv @@
// One deque slot: holds a word, shifts with its neighbors, taps onto the read chain.
module cdq_cell (
	input  logic                        clk,
	input  cdq_pkg::cell_ctl_t          ctl,
	input  logic                        tail_sel,
	input  logic                        read_sel,
	input  logic [cdq_pkg::DATA_W-1:0]  push_data,
	input  logic [cdq_pkg::DATA_W-1:0]  from_prev,
	input  logic [cdq_pkg::DATA_W-1:0]  from_next,
	input  logic [cdq_pkg::DATA_W-1:0]  rd_in,
	output logic [cdq_pkg::DATA_W-1:0]  slot,
	output logic [cdq_pkg::DATA_W-1:0]  rd_out
);

	logic [cdq_pkg::DATA_W-1:0] slot_q;

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			slot_q <= from_prev;
		end else if (ctl.pop_front) begin
			slot_q <= from_next;
		end else if (ctl.push_back && tail_sel) begin
			slot_q <= push_data;
		end
	end

	assign slot   = slot_q;
	assign rd_out = rd_in | (read_sel ? slot_q : '0);

endmodule

@@ sv/circular_deque.sv @@
// Deque top level: request decode, count and capacity, row of slot cells, result register.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+----------------------------
//  request  | start, busy, req_type, push_data          | taken when start && !busy
//  result   | done, status, pop_data, item_count        | one-cycle strobe on done
//  config   | cfg_valid, cfg_ready, cfg_data            | written when valid && ready
//
// One request per cycle; the result is registered and shows in the cycle after the request is taken.
// Items sit front-first in a row of cells; a front push/pop shifts the whole row
// by one slot, a back push/pop touches the cell picked by the count.
// Reset empties the queue and sets capacity to the full depth; a capacity write
// empties the queue as well. The result side has no stall.
module circular_deque (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [cdq_pkg::REQ_W-1:0]    req_type,
	input  logic [cdq_pkg::DATA_W-1:0]   push_data,
	output logic                         done,
	output logic [cdq_pkg::STAT_W-1:0]   status,
	output logic [cdq_pkg::DATA_W-1:0]   pop_data,
	output logic [cdq_pkg::CNT_W-1:0]    item_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]    cfg_data
);

	logic [cdq_pkg::CNT_W-1:0]  count_q;
	logic [cdq_pkg::CAP_W-1:0]  cap_q;
	logic                       done_q;
	logic [cdq_pkg::STAT_W-1:0] status_q;
	logic [cdq_pkg::DATA_W-1:0] pop_data_q;
	logic [cdq_pkg::CNT_W-1:0]  item_count_q;

	logic                       accept;
	logic                       cfg_wr;
	logic                       is_push;
	logic                       full;
	logic                       empty;
	logic                       ok;
	logic [cdq_pkg::STAT_W-1:0] status_nxt;
	logic [cdq_pkg::CNT_W-1:0]  count_nxt;
	logic [cdq_pkg::CNT_W-1:0]  count_dec;
	logic [cdq_pkg::CAP_W-1:0]  cap_nxt;
	cdq_pkg::cell_ctl_t         ctl;
	logic                       pop_back;
	logic                       pop_front;

	logic [cdq_pkg::DEPTH-1:0]  tail_sel;
	logic [cdq_pkg::DEPTH-1:0]  read_sel;
	logic [cdq_pkg::DATA_W-1:0] slot [cdq_pkg::DEPTH];
	logic [cdq_pkg::DATA_W-1:0] rd_chain [cdq_pkg::DEPTH+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign full      = count_q >= cdq_pkg::CNT_W'(cap_q);
	assign empty     = count_q == '0;
	assign count_dec = count_q - cdq_pkg::CNT_W'(1);

	// clamp capacity into 1..DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_nxt = cdq_pkg::CAP_W'(1);
		end else if (cfg_data > cdq_pkg::CAP_W'(cdq_pkg::DEPTH)) begin
			cap_nxt = cdq_pkg::CAP_W'(cdq_pkg::DEPTH);
		end else begin
			cap_nxt = cfg_data;
		end
	end

	always_comb begin
		is_push   = 1'b0;
		ok        = 1'b0;
		ctl       = '0;
		pop_front = 1'b0;
		pop_back  = 1'b0;
		unique case (req_type)
			cdq_pkg::REQ_PUSH_BACK: begin
				is_push        = 1'b1;
				ok             = !full;
				ctl.push_back  = accept && !full;
			end
			cdq_pkg::REQ_PUSH_FRONT: begin
				is_push        = 1'b1;
				ok             = !full;
				ctl.push_front = accept && !full;
			end
			cdq_pkg::REQ_POP_FRONT: begin
				ok             = !empty;
				ctl.pop_front  = accept && !empty;
				pop_front      = accept && !empty;
			end
			cdq_pkg::REQ_POP_BACK: begin
				ok             = !empty;
				pop_back       = accept && !empty;
			end
			default: begin
				ok = 1'b0;
			end
		endcase

		if (!ok) begin
			status_nxt = is_push ? cdq_pkg::ST_FULL : cdq_pkg::ST_EMPTY;
			count_nxt  = count_q;
		end else begin
			status_nxt = cdq_pkg::ST_OK;
			count_nxt  = is_push ? count_q + cdq_pkg::CNT_W'(1) : count_dec;
		end
	end

	// per-cell selects: back push lands at count, back pop reads count-1
	always_comb begin
		for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
			tail_sel[i] = count_q[cdq_pkg::IDX_W-1:0] == cdq_pkg::IDX_W'(i);
			read_sel[i] = (pop_back && (count_dec[cdq_pkg::IDX_W-1:0] == cdq_pkg::IDX_W'(i)))
				|| (pop_front && (i == 0));
		end
	end

	assign rd_chain[0] = '0;

	for (genvar g = 0; g < cdq_pkg::DEPTH; g++) begin : g_cell
		logic [cdq_pkg::DATA_W-1:0] prev_word;
		logic [cdq_pkg::DATA_W-1:0] next_word;

		if (g == 0) begin : g_first
			assign prev_word = push_data;
		end else begin : g_mid
			assign prev_word = slot[g-1];
		end

		if (g == cdq_pkg::DEPTH - 1) begin : g_last
			assign next_word = '0;
		end else begin : g_inner
			assign next_word = slot[g+1];
		end

		cdq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.tail_sel  (tail_sel[g]),
			.read_sel  (read_sel[g]),
			.push_data (push_data),
			.from_prev (prev_word),
			.from_next (next_word),
			.rd_in     (rd_chain[g]),
			.slot      (slot[g]),
			.rd_out    (rd_chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= cdq_pkg::CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (cfg_wr) begin
				cap_q   <= cap_nxt;
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	// result word; rd_chain is zero unless a pop succeeded
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_nxt;
			pop_data_q   <= rd_chain[cdq_pkg::DEPTH];
			item_count_q <= count_nxt;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign pop_data   = pop_data_q;
	assign item_count = item_count_q;

endmodule

@@ tb/sv/deque_checker.sv @@
// Deque checker: watches the request, result and capacity channels, predicts and compares.
module deque_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [cdq_pkg::REQ_W-1:0]    req_type,
	input  logic [cdq_pkg::DATA_W-1:0]   push_data,
	input  logic                         done,
	input  logic [cdq_pkg::STAT_W-1:0]   status,
	input  logic [cdq_pkg::DATA_W-1:0]   pop_data,
	input  logic [cdq_pkg::CNT_W-1:0]    item_count,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]    cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           n_requests,
	output int                           n_results,
	output int                           n_full,
	output int                           n_empty
);
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  count;
	} deque_result_t;

	logic [DATA_W-1:0] held_words[$];  // front of the deque at index 0
	int                slots_usable;
	deque_result_t     awaited_results[$];

	function automatic int usable_slots(logic [CAP_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (int'(raw) > DEPTH)
			return DEPTH;
		return int'(raw);
	endfunction

	// Applies one request to the shadow deque and returns the result it should give.
	function automatic deque_result_t apply_request(logic [REQ_W-1:0] rt, logic [DATA_W-1:0] w);
		deque_result_t r;
		r.status = ST_OK;
		r.word   = '0;
		case (rt)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (held_words.size() >= slots_usable)
					r.status = ST_FULL;
				else if (rt == REQ_PUSH_BACK)
					held_words.push_back(w);
				else
					held_words.push_front(w);
			end
			default: begin
				if (held_words.size() == 0)
					r.status = ST_EMPTY;
				else if (rt == REQ_POP_FRONT)
					r.word = held_words.pop_front();
				else
					r.word = held_words.pop_back();
			end
		endcase
		r.count = CNT_W'(held_words.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want, got;
		if (!arst_n) begin
			held_words.delete();
			awaited_results.delete();
			slots_usable = usable_slots(CAP_RESET);
			fail_count = 0;
			n_requests = 0;
			n_results  = 0;
			n_full     = 0;
			n_empty    = 0;
		end else begin
			if (done) begin
				got = '{status: status, word: pop_data, count: item_count};
				n_results++;
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: unexpected result status %0d word %h count %0d",
							$realtime, got.status, got.word, got.count);
				end else begin
					want = awaited_results.pop_front();
					if (got.status !== want.status || got.word !== want.word ||
						got.count !== want.count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: mismatch status %0d/%0d word %h/%h count %0d/%0d (want/got)",
								$realtime, want.status, got.status, want.word, got.word,
								want.count, got.count);
					end
				end
			end
			if (start && !busy) begin
				want = apply_request(req_type, push_data);
				if (want.status == ST_FULL)
					n_full++;
				if (want.status == ST_EMPTY)
					n_empty++;
				n_requests++;
				awaited_results.push_back(want);
			end
			// a capacity write empties the deque
			if (cfg_valid && cfg_ready) begin
				slots_usable = usable_slots(cfg_data);
				held_words.delete();
			end
		end
		pending = awaited_results.size();
	end

endmodule

@@ tb/sv/circular_deque_tb.sv @@
// Testbench top for the circular deque: clock, reset, request stimulus and verdict.
module circular_deque_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [REQ_W-1:0]   req_type;
	logic [DATA_W-1:0]  push_data;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [DATA_W-1:0]  pop_data;
	logic [CNT_W-1:0]   item_count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CAP_W-1:0]   cfg_data;

	int fails, pending, n_requests, n_results, n_full, n_empty;
	int idle_pct;

	circular_deque uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .req_type(req_type), .push_data(push_data),
		.done(done), .status(status), .pop_data(pop_data), .item_count(item_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	deque_checker chk (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .req_type(req_type), .push_data(push_data),
		.done(done), .status(status), .pop_data(pop_data), .item_count(item_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fails), .pending(pending), .n_requests(n_requests),
		.n_results(n_results), .n_full(n_full), .n_empty(n_empty)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Hands one request word to the block, idling first at the current rate.
	task automatic send_request(logic [REQ_W-1:0] rt, logic [DATA_W-1:0] w);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			req_type = REQ_W'($urandom);
			push_data = $urandom;
		end
		@(negedge clk);
		start = 1'b1;
		req_type = rt;
		push_data = w;
		do @(posedge clk); while (busy);
	endtask

	// Stops requesting and waits until every result has come back.
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		drain_results();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = CAP_W'($urandom);
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Alternates filling and draining bursts so full and empty are hit often.
	task automatic random_phase(logic [CAP_W-1:0] cap, int pct, int n);
		int push_pct;
		int burst_left;
		logic [REQ_W-1:0] rt;
		push_pct = 80;
		burst_left = 0;
		idle_pct = 0;
		write_capacity(cap);
		idle_pct = pct;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 8);
				push_pct = (push_pct == 80) ? 25 : 80;
			end
			burst_left--;
			if (i == n / 2)
				drain_results();
			if ($urandom_range(99) < push_pct)
				rt = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
			else
				rt = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
			send_request(rt, random_word());
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps[8];
		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd2, 5'd16};
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_PUSH_BACK;
		push_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pops, data extremes at both ends, then small capacities
		send_request(REQ_POP_FRONT, 32'hDEAD_BEEF);
		send_request(REQ_POP_BACK, 32'h1234_5678);
		send_request(REQ_PUSH_BACK, 32'h0000_0000);
		send_request(REQ_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
		send_request(REQ_PUSH_FRONT, 32'h5555_5555);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_POP_BACK, '0);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_FRONT, '0);
		write_capacity(5'd0);  // zero acts as one slot
		send_request(REQ_PUSH_BACK, 32'h8000_0001);
		send_request(REQ_PUSH_FRONT, 32'h0F0F_0F0F);
		send_request(REQ_PUSH_BACK, 32'hF0F0_F0F0);
		send_request(REQ_POP_BACK, '1);
		send_request(REQ_POP_FRONT, '1);
		write_capacity(5'd2);
		send_request(REQ_PUSH_FRONT, 32'h0000_0001);
		send_request(REQ_PUSH_FRONT, 32'h8000_0000);
		send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
		send_request(REQ_POP_FRONT, '0);
		send_request(REQ_POP_FRONT, '0);

		// phases cycle through no idling, sender idle 49%, none, sender idle 36%
		for (int p = 0; p < 8; p++)
			random_phase(caps[p], (p % 4 == 1) ? 49 : (p % 4 == 3) ? 36 : 0, 116);

		drain_results();
		repeat (4) @(posedge clk);
		$display("Covered %0d requests, %0d results (%0d full, %0d empty statuses)",
			n_requests, n_results, n_full, n_empty);
		$display("Capacities 0, 1, 2, 5, 16, 17 and 31 with sender idling at 0, 36 and 49 percent");
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still awaited", pending);
		$display("TB_ERROR");
		$finish;
	end

endmodule
